/* rtl/tgnc_pkg.sv */
// shared types, constants and helpers for the torus grid neighbor cover block
package tgnc_pkg;

  localparam int MAX_CELLS   = 4096;
  localparam int MAX_COLUMNS = 64;
  localparam int ROW_LIMIT   = 64;

  localparam int CELL_W    = 12;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int CFG_W     = 7;
  localparam int SIZE_W    = CELL_W + 1;
  localparam int KEY_W     = CELL_W + 1;
  localparam int COUNT_W   = 4;
  localparam int NBR_MAX   = 8;
  localparam int DIV_CNT_W = $clog2(CELL_W + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_KING = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              op;
    logic [CELL_W-1:0] cell_req;
    logic              mark_value;
  } in_word_t;

  typedef struct packed {
    logic [CELL_W-1:0]  neighbor_cell;
    logic               wrapped;
    logic               found;
    logic [COUNT_W-1:0] cover_count;
    logic               last;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              op;
    logic [CELL_W-1:0] cell_idx;
    logic              mark;
    logic              in_grid;
    logic [COL_W-1:0]  col;
    logic [CFG_W-1:0]  cols;
    logic [SIZE_W-1:0] size;
    logic              king;
  } item_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

/* rtl/tgnc_ram.sv */
// generic single-port ram with registered read
module tgnc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tgnc_queue.sv */
// two-entry queue of classified items between front and back
module tgnc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tgnc_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output tgnc_pkg::item_t head_item,
  output logic            empty
);
  import tgnc_pkg::*;

  item_t      ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_item = ent_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) ent_r[wp_r] <= push_item;
  end

endmodule

/* rtl/tgnc_front.sv */
// front end: accepts words, finds the column of a queried cell by serial division
module tgnc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  tgnc_pkg::in_word_t             in_word,
  output logic                           full,
  input  logic                           hold_off,
  input  logic [tgnc_pkg::CFG_W-1:0]     cols,
  input  logic [tgnc_pkg::CFG_W-1:0]     rows,
  input  logic                           king,
  output logic                           q_push,
  output tgnc_pkg::item_t                q_item,
  input  logic                           q_full
);
  import tgnc_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_HOLD} fstate_t;

  fstate_t              state_r, state_nxt;
  item_t                item_r, item_nxt;
  logic [CELL_W-1:0]    div_r, div_nxt;
  logic [COL_W:0]       rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]    size_c;
  logic [2*CFG_W-1:0]   prod;
  logic [COL_W:0]       trial;

  assign prod   = cols * rows;
  assign size_c = prod[SIZE_W-1:0];
  assign full   = (state_r != F_IDLE) || hold_off;
  assign trial  = {rem_r[COL_W-1:0], div_r[CELL_W-1]};

  always_comb begin
    q_item     = item_r;
    q_item.col = rem_r[COL_W-1:0];
    q_push     = (state_r == F_HOLD) && !q_full;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      F_IDLE: begin
        if (push && !hold_off) begin
          item_nxt.op       = in_word.op;
          item_nxt.cell_idx = in_word.cell_req;
          item_nxt.mark     = in_word.mark_value;
          item_nxt.in_grid  = {1'b0, in_word.cell_req} < size_c;
          item_nxt.col      = '0;
          item_nxt.cols     = cols;
          item_nxt.size     = size_c;
          item_nxt.king     = king;
          div_nxt           = in_word.cell_req;
          rem_nxt           = '0;
          cnt_nxt           = DIV_CNT_W'(CELL_W);
          state_nxt         = (in_word.op == OP_QUERY) ? F_DIV : F_HOLD;
        end
      end
      F_DIV: begin
        rem_nxt = (trial >= cols) ? trial - cols : trial;
        div_nxt = {div_r[CELL_W-2:0], 1'b0};
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) state_nxt = F_HOLD;
      end
      F_HOLD: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    item_r <= item_nxt;
    div_r  <= div_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

/* rtl/tgnc_back.sv */
// back end: mark memory, neighbor scan, sorted insertion and result output
module tgnc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  tgnc_pkg::item_t           q_item,
  output logic                      q_pop,
  output logic                      clearing,
  output logic                      empty,
  input  logic                      pop,
  output tgnc_pkg::out_word_t       out_word
);
  import tgnc_pkg::*;

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_SCAN, B_EMIT} bstate_t;
  typedef enum logic [2:0] {
    DIR_N, DIR_NE, DIR_E, DIR_SE, DIR_S, DIR_SW, DIR_W, DIR_NW
  } dir_t;

  bstate_t            state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  item_t              cur_r, cur_nxt;
  logic [3:0]         k_r, k_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [KEY_W-1:0]   pend_key_r, pend_key_nxt;
  logic [KEY_W-1:0]   keys_r [NBR_MAX];
  logic [KEY_W-1:0]   keys_nxt [NBR_MAX];
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [2:0]         e_r, e_nxt;
  logic               out_v_r, out_v_nxt;
  out_word_t          out_r, out_nxt;

  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_we;
  logic               ram_wdata;
  logic               ram_rdata;

  logic [KEY_W-1:0]   c13, cols13, size13, col13, t_n, t_s, t, cand;
  logic               wv, wh;
  dir_t               dir;
  logic [KEY_W-1:0]   key;
  logic               le [NBR_MAX];
  logic               ins;
  logic               ld_out;
  logic               is_last;

  tgnc_ram #(.WIDTH(1), .DEPTH(MAX_CELLS)) u_mark_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign clearing = (state_r == B_CLEAR);
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign empty    = !out_v_r;
  assign out_word = out_r;

  // neighbor address for the current direction
  always_comb begin
    c13    = KEY_W'(cur_r.cell_idx);
    cols13 = KEY_W'(cur_r.cols);
    size13 = KEY_W'(cur_r.size);
    col13  = KEY_W'(cur_r.col);
    dir    = dir_t'(k_r[2:0]);
    t_n    = (c13 < cols13) ? size13 - cols13 + c13 : c13 - cols13;
    t_s    = (c13 < size13 - cols13) ? c13 + cols13 : col13;
    case (dir) inside
      DIR_N, DIR_NE, DIR_NW: begin
        t  = t_n;
        wv = (c13 < cols13);
      end
      DIR_SE, DIR_S, DIR_SW: begin
        t  = t_s;
        wv = !(c13 < size13 - cols13);
      end
      default: begin
        t  = c13;
        wv = 1'b0;
      end
    endcase
    case (dir) inside
      DIR_NE, DIR_E, DIR_SE: begin
        wh   = ({1'b0, cur_r.col} == cur_r.cols - CFG_W'(1));
        cand = wh ? t + KEY_W'(1) - cols13 : t + KEY_W'(1);
      end
      DIR_SW, DIR_W, DIR_NW: begin
        wh   = (cur_r.col == '0);
        cand = wh ? t + cols13 - KEY_W'(1) : t - KEY_W'(1);
      end
      default: begin
        wh   = 1'b0;
        cand = t;
      end
    endcase
    key = {cand[CELL_W-1:0], wv || wh};
  end

  // sorted insertion of a marked neighbor
  always_comb begin
    ins = pend_v_r && ram_rdata;
    for (int j = 0; j < NBR_MAX; j++) begin
      le[j] = (COUNT_W'(j) < n_r) && (keys_r[j] <= pend_key_r);
    end
    keys_nxt[0] = (!ins || le[0]) ? keys_r[0] : pend_key_r;
    for (int j = 1; j < NBR_MAX; j++) begin
      if (!ins || le[j]) keys_nxt[j] = keys_r[j];
      else if (le[j-1]) keys_nxt[j] = pend_key_r;
      else keys_nxt[j] = keys_r[j-1];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    pend_v_nxt   = 1'b0;
    pend_key_nxt = key;
    n_nxt        = ins ? n_r + COUNT_W'(1) : n_r;
    e_nxt        = e_r;
    out_nxt      = out_r;
    ram_addr     = cand[ADDR_W-1:0];
    ram_we       = 1'b0;
    ram_wdata    = 1'b0;
    ld_out       = (state_r == B_EMIT) && (!out_v_r || pop);
    is_last      = (n_r == '0) || (COUNT_W'(e_r) + COUNT_W'(1) == n_r);
    out_v_nxt    = ld_out ? 1'b1 : ((pop && out_v_r) ? 1'b0 : out_v_r);
    unique case (state_r)
      B_CLEAR: begin
        ram_addr = clr_r;
        ram_we   = 1'b1;
        clr_nxt  = clr_r + ADDR_W'(1);
        if (clr_r == '1) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        ram_addr  = q_item.cell_idx[ADDR_W-1:0];
        ram_wdata = q_item.mark;
        if (!q_empty) begin
          if (q_item.op == OP_WRITE) begin
            ram_we = 1'b1;
          end else begin
            cur_nxt   = q_item;
            n_nxt     = '0;
            k_nxt     = '0;
            e_nxt     = '0;
            state_nxt = q_item.in_grid ? B_SCAN : B_EMIT;
          end
        end
      end
      B_SCAN: begin
        if (!k_r[3]) begin
          pend_v_nxt = 1'b1;
          k_nxt      = k_r + (cur_r.king ? 4'd1 : 4'd2);
        end else begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (ld_out) begin
          if (n_r == '0) begin
            out_nxt = '{neighbor_cell: '0, wrapped: 1'b0, found: 1'b0,
                        cover_count: '0, last: 1'b1};
          end else begin
            out_nxt = '{neighbor_cell: keys_r[e_r][KEY_W-1:1],
                        wrapped: keys_r[e_r][0], found: 1'b1,
                        cover_count: n_r, last: is_last};
          end
          e_nxt = e_r + 3'd1;
          if (is_last) state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLEAR;
      clr_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    pend_key_r <= pend_key_nxt;
    n_r        <= n_nxt;
    e_r        <= e_nxt;
    out_r      <= out_nxt;
    for (int j = 0; j < NBR_MAX; j++) keys_r[j] <= keys_nxt[j];
  end

endmodule

/* rtl/torus_grid_neighbor_cover.sv */
// top level of the torus grid neighbor cover block
//
// Input queue side: push an in_word while full is low. A word with op write
// stores mark_value for cell_req; a word with op query asks which marked
// cells are king (or square) neighbors of cell_req on the wrapped grid.
// Result queue side: while empty is low the oldest result sits on out_word;
// pop takes it. A query yields one result per marked neighbor in ascending
// neighbor order, last set on the final one, or one result with found low.
// Geometry and neighbor mode come from three registers on the apb port:
// columns at 0x0, rows at 0x4, king mode at 0x8; write them only when idle.
// A query first passes the front end, where the one-bit-per-cycle column
// divider finds its column, then the back end, which reads the mark memory
// one neighbor per cycle and then emits its results in order as the output
// register frees. A write skips the divider and stores its mark in the back
// end. Front and back overlap through a two-entry queue, so the front end
// can take a new word while the back end still works on an earlier one.
// After reset the mark memory is swept to zero; full stays high during the
// sweep. A stalled receiver fills the output register, then the queue, then
// holds full high; no result is dropped.
module torus_grid_neighbor_cover (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tgnc_pkg::in_word_t    in_word,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output tgnc_pkg::out_word_t   out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import tgnc_pkg::*;

  logic [CFG_W-1:0] cols_cfg_r;
  logic [CFG_W-1:0] rows_cfg_r;
  logic             king_r;
  logic             cfg_we;
  reg_idx_t         reg_idx;
  logic [CFG_W-1:0] cols_c, rows_c;

  logic             q_push, q_full, q_pop, q_empty;
  item_t            q_in, q_head;
  logic             clearing;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cols_c  = clamp_dim(cols_cfg_r, CFG_W'(MAX_COLUMNS));
  assign rows_c  = clamp_dim(rows_cfg_r, CFG_W'(ROW_LIMIT));

  always_comb begin
    unique case (reg_idx)
      REG_COLS: prdata = 32'(cols_cfg_r);
      REG_ROWS: prdata = 32'(rows_cfg_r);
      REG_KING: prdata = 32'(king_r);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= CFG_W'(8);
      rows_cfg_r <= CFG_W'(8);
      king_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_COLS: cols_cfg_r <= pwdata[CFG_W-1:0];
        REG_ROWS: rows_cfg_r <= pwdata[CFG_W-1:0];
        REG_KING: king_r     <= pwdata[0];
        default:  ;
      endcase
    end
  end

  tgnc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .hold_off (clearing),
    .cols     (cols_c),
    .rows     (rows_c),
    .king     (king_r),
    .q_push   (q_push),
    .q_item   (q_in),
    .q_full   (q_full)
  );

  tgnc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head_item (q_head),
    .empty     (q_empty)
  );

  tgnc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
